FILE: rtl/core/bsa_pkg.sv
// Shared constants, types and command/status structs for the banker's allocator.
package bsa_pkg;

	localparam int NUM_RES       = 4;
	localparam int MAX_CUSTOMERS = 8;
	localparam int COUNT_WIDTH   = 16;
	localparam int AMOUNT_FIELDS = 4;
	localparam int AMT_W         = 16;
	localparam int SLOT_W        = 3;
	localparam int KIND_W        = 2;
	localparam int STATUS_W      = 3;

	localparam int CUST_W = (MAX_CUSTOMERS > 1) ? $clog2(MAX_CUSTOMERS) : 1;
	localparam int SCAN_W = $clog2(MAX_CUSTOMERS + 1);
	// available plus every allocation stays below (MAX_CUSTOMERS+1) * 2^COUNT_WIDTH
	localparam int WORK_W = COUNT_WIDTH + CUST_W + 1;

	typedef logic [COUNT_WIDTH-1:0]              cnt_t;
	typedef logic [NUM_RES-1:0][COUNT_WIDTH-1:0] vec_t;
	typedef logic [NUM_RES-1:0][WORK_W-1:0]      work_t;

	typedef struct packed {
		vec_t need;
		vec_t alloc;
	} row_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_SET_AVAIL = 2'd0,
		KIND_REGISTER  = 2'd1,
		KIND_REQUEST   = 2'd2,
		KIND_RELEASE   = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_SLOT_STATE = 3'd1,
		ST_OVER_NEED  = 3'd2,
		ST_OVER_AVAIL = 3'd3,
		ST_UNSAFE     = 3'd4
	} status_t;

	typedef struct packed {
		logic              load_item;
		logic              set_avail;
		logic              reg_slot;
		logic              rd_slot;
		logic              release_slot;
		logic              grant;
		logic              rollback;
		logic              scan_rd;
		logic              scan_eval;
		logic              scan_restart;
		logic [CUST_W-1:0] scan_idx;
		logic [CUST_W-1:0] eval_idx;
	} bsa_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  slot_bad;
		logic  over_need;
		logic  over_avail;
		logic  all_done;
		logic  progress;
	} bsa_stat_t;

endpackage

FILE: rtl/core/bsa_if.sv
// Valid/ready channel interfaces for input items and results.
interface bsa_in_if;
	logic                      valid;
	logic                      ready;
	logic [bsa_pkg::KIND_W-1:0] kind;
	logic [bsa_pkg::SLOT_W-1:0] slot;
	logic [bsa_pkg::AMT_W-1:0]  amount_0;
	logic [bsa_pkg::AMT_W-1:0]  amount_1;
	logic [bsa_pkg::AMT_W-1:0]  amount_2;
	logic [bsa_pkg::AMT_W-1:0]  amount_3;

	modport source (output valid, kind, slot, amount_0, amount_1, amount_2, amount_3,
		input ready);
	modport sink (input valid, kind, slot, amount_0, amount_1, amount_2, amount_3,
		output ready);
endinterface

interface bsa_out_if;
	logic                         valid;
	logic                         ready;
	logic                         granted;
	logic [bsa_pkg::STATUS_W-1:0] status;

	modport source (output valid, granted, status, input ready);
	modport sink (input valid, granted, status, output ready);
endinterface

FILE: rtl/core/bsa_datapath.sv
// Datapath: available vector, customer table, safety-check work vector.
module bsa_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bsa_pkg::bsa_cmd_t          cmd,
	input  logic [bsa_pkg::KIND_W-1:0] in_kind,
	input  logic [bsa_pkg::SLOT_W-1:0] in_slot,
	input  logic [bsa_pkg::AMT_W-1:0]  in_amount_0,
	input  logic [bsa_pkg::AMT_W-1:0]  in_amount_1,
	input  logic [bsa_pkg::AMT_W-1:0]  in_amount_2,
	input  logic [bsa_pkg::AMT_W-1:0]  in_amount_3,
	output bsa_pkg::bsa_stat_t         stat
);
	import bsa_pkg::*;

	kind_t                    kind_q;
	logic [SLOT_W-1:0]        slot_q;
	vec_t                     vec_q;
	vec_t                     avail_q;
	logic [MAX_CUSTOMERS-1:0] active_q;
	row_t                     mem_q [MAX_CUSTOMERS];
	row_t                     rd_q;
	row_t                     srow_q;
	work_t                    work_q;
	logic [MAX_CUSTOMERS-1:0] done_q;
	logic                     progress_q;

	logic [AMT_W-1:0]         amt [AMOUNT_FIELDS];
	vec_t                     vec_in;
	logic [CUST_W-1:0]        slot_idx;
	logic                     slot_oob;
	logic                     fit;
	logic [MAX_CUSTOMERS-1:0] done_nxt;
	logic                     progress_nxt;
	row_t                     grant_row;
	vec_t                     rel_avail;
	logic [COUNT_WIDTH:0]     sum;
	logic                     we;
	row_t                     wdata;
	logic [CUST_W-1:0]        raddr;

	assign amt[0] = in_amount_0;
	assign amt[1] = in_amount_1;
	assign amt[2] = in_amount_2;
	assign amt[3] = in_amount_3;

	always_comb begin
		for (int r = 0; r < NUM_RES; r++) begin
			vec_in[r] = '0;
			if (r < AMOUNT_FIELDS) begin
				vec_in[r] = COUNT_WIDTH'(amt[r]);
			end
		end
	end

	assign slot_idx = CUST_W'(slot_q);
	assign slot_oob = (int'(slot_q) >= MAX_CUSTOMERS);

	// item decode status
	always_comb begin
		stat.kind       = kind_q;
		stat.slot_bad   = slot_oob ||
			((kind_q == KIND_REGISTER) ? active_q[slot_idx] : !active_q[slot_idx]);
		stat.over_need  = 1'b0;
		stat.over_avail = 1'b0;
		for (int r = 0; r < NUM_RES; r++) begin
			if (vec_q[r] > rd_q.need[r]) stat.over_need = 1'b1;
			if (vec_q[r] > avail_q[r]) stat.over_avail = 1'b1;
		end
		stat.all_done = &done_nxt;
		stat.progress = progress_nxt;
	end

	// one customer of the safety scan per cycle
	always_comb begin
		fit = !done_q[cmd.eval_idx];
		for (int r = 0; r < NUM_RES; r++) begin
			if (WORK_W'(rd_q.need[r]) > work_q[r]) fit = 1'b0;
		end
		done_nxt     = done_q;
		progress_nxt = progress_q;
		if (cmd.scan_eval && fit) begin
			done_nxt[cmd.eval_idx] = 1'b1;
			progress_nxt           = 1'b1;
		end
	end

	always_comb begin
		sum = '0;
		for (int r = 0; r < NUM_RES; r++) begin
			grant_row.need[r]  = rd_q.need[r] - vec_q[r];
			grant_row.alloc[r] = rd_q.alloc[r] + vec_q[r];
			sum          = {1'b0, avail_q[r]} + {1'b0, rd_q.alloc[r]};
			rel_avail[r] = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
		end
	end

	always_comb begin
		we    = cmd.reg_slot || cmd.grant || cmd.rollback;
		wdata = srow_q;
		if (cmd.reg_slot) begin
			wdata.need  = vec_q;
			wdata.alloc = '0;
		end else if (cmd.grant) begin
			wdata = grant_row;
		end
		raddr = cmd.rd_slot ? slot_idx : cmd.scan_idx;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[slot_idx] <= wdata;
		end
		if (cmd.rd_slot || cmd.scan_rd) begin
			rd_q <= mem_q[raddr];
		end
	end

	// item and scan payload
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q <= kind_t'(in_kind);
			slot_q <= in_slot;
			vec_q  <= vec_in;
		end
		if (cmd.grant) begin
			srow_q <= rd_q;
			for (int r = 0; r < NUM_RES; r++) begin
				work_q[r] <= WORK_W'(avail_q[r] - vec_q[r]);
			end
		end else if (cmd.scan_eval && fit) begin
			for (int r = 0; r < NUM_RES; r++) begin
				work_q[r] <= work_q[r] + WORK_W'(rd_q.alloc[r]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avail_q    <= '0;
			active_q   <= '0;
			done_q     <= '0;
			progress_q <= 1'b0;
		end else begin
			if (cmd.set_avail) begin
				avail_q <= vec_q;
			end else if (cmd.release_slot) begin
				avail_q <= rel_avail;
			end else if (cmd.grant) begin
				for (int r = 0; r < NUM_RES; r++) avail_q[r] <= avail_q[r] - vec_q[r];
			end else if (cmd.rollback) begin
				for (int r = 0; r < NUM_RES; r++) avail_q[r] <= avail_q[r] + vec_q[r];
			end
			if (cmd.reg_slot) active_q[slot_idx] <= 1'b1;
			if (cmd.release_slot) active_q[slot_idx] <= 1'b0;
			if (cmd.grant) begin
				done_q     <= ~active_q;
				progress_q <= 1'b0;
			end else begin
				done_q     <= done_nxt;
				progress_q <= cmd.scan_restart ? 1'b0 : progress_nxt;
			end
		end
	end

endmodule

FILE: rtl/core/bsa_ctrl.sv
// Controller: item sequencing, safety scan passes, result register.
module bsa_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         out_granted,
	output logic [bsa_pkg::STATUS_W-1:0] out_status,
	input  bsa_pkg::bsa_stat_t           stat,
	output bsa_pkg::bsa_cmd_t            cmd
);
	import bsa_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_CHECK,
		S_SCAN,
		S_RESULT
	} state_t;

	state_t            state_q;
	logic [SCAN_W-1:0] k_q;
	status_t           res_q;
	status_t           out_status_q;
	logic              out_valid_q;
	logic              pass_end;
	logic [SCAN_W-1:0] k_prev;

	assign pass_end = (k_q == SCAN_W'(MAX_CUSTOMERS));
	assign k_prev   = k_q - 1'b1;

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign out_status  = out_status_q;
	assign out_granted = (out_status_q == ST_OK);

	always_comb begin
		cmd          = '0;
		cmd.scan_idx = CUST_W'(k_q);
		cmd.eval_idx = CUST_W'(k_prev);
		case (state_q)
			S_IDLE:   cmd.load_item = in_valid;
			S_DECODE: begin
				case (stat.kind)
					KIND_SET_AVAIL: cmd.set_avail = 1'b1;
					KIND_REGISTER:  cmd.reg_slot  = !stat.slot_bad;
					default:        cmd.rd_slot   = !stat.slot_bad;
				endcase
			end
			S_CHECK: begin
				if (stat.kind == KIND_RELEASE) begin
					cmd.release_slot = 1'b1;
				end else begin
					cmd.grant = !stat.over_need && !stat.over_avail;
				end
			end
			S_SCAN: begin
				cmd.scan_rd   = !pass_end;
				cmd.scan_eval = (k_q != '0);
				if (pass_end) begin
					cmd.scan_restart = stat.progress && !stat.all_done;
					cmd.rollback     = !stat.progress && !stat.all_done;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			k_q          <= '0;
			res_q        <= ST_OK;
			out_status_q <= ST_OK;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_DECODE;
				end
				S_DECODE: begin
					if (stat.kind == KIND_SET_AVAIL) begin
						res_q   <= ST_OK;
						state_q <= S_RESULT;
					end else if (stat.slot_bad) begin
						res_q   <= ST_SLOT_STATE;
						state_q <= S_RESULT;
					end else if (stat.kind == KIND_REGISTER) begin
						res_q   <= ST_OK;
						state_q <= S_RESULT;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (stat.kind == KIND_RELEASE) begin
						res_q   <= ST_OK;
						state_q <= S_RESULT;
					end else if (stat.over_need) begin
						res_q   <= ST_OVER_NEED;
						state_q <= S_RESULT;
					end else if (stat.over_avail) begin
						res_q   <= ST_OVER_AVAIL;
						state_q <= S_RESULT;
					end else begin
						k_q     <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (!pass_end) begin
						k_q <= k_q + 1'b1;
					end else if (stat.all_done) begin
						res_q   <= ST_OK;
						state_q <= S_RESULT;
					end else if (stat.progress) begin
						k_q <= '0;
					end else begin
						res_q   <= ST_UNSAFE;
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_DECODE))
		else $error("accepted transaction not decoded");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (k_q <= SCAN_W'(MAX_CUSTOMERS)))
		else $error("scan index out of range");
	a_grant_once: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.grant && cmd.rollback))
		else $error("grant and rollback together");
	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESULT && (!out_valid_q || out_ready)) |=>
		(out_valid_q && out_status_q == $past(res_q)))
		else $error("result not loaded");
`endif

endmodule

FILE: rtl/core/bankers_safety_allocator_top.sv
// Top level: banker's-algorithm allocator with safety check.
// Flow: set-available and register pass from accept through decode to the result register,
// as do slot-state refusals; release and over-need/over-available refusals also pass the
// check state; a checked request also runs P scan passes, P = scan passes (1..MAX_CUSTOMERS),
// each reading every table row; the result load waits while an earlier result is unaccepted.
// Throughput: one transaction at a time; a new item is taken only once the result is loaded.
// Reset: arst_n clears available, active slots and all control; the table needs no clear.
module bankers_safety_allocator_top (
	input logic     clk,
	input logic     arst_n,
	bsa_in_if.sink  item,
	bsa_out_if.source result
);
	import bsa_pkg::*;

	bsa_cmd_t  cmd;
	bsa_stat_t stat;

	// Controller owns the handshakes and the result register; the datapath owns all
	// resource state. The customer table sits in the datapath with one registered read.
	bsa_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (item.valid),
		.in_ready    (item.ready),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.out_granted (result.granted),
		.out_status  (result.status),
		.stat        (stat),
		.cmd         (cmd)
	);

	// Safety scan: one customer row read per cycle, evaluated the next cycle
	// against the running work vector; passes repeat while a pass finished a customer and some remain.
	bsa_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_kind     (item.kind),
		.in_slot     (item.slot),
		.in_amount_0 (item.amount_0),
		.in_amount_1 (item.amount_1),
		.in_amount_2 (item.amount_2),
		.in_amount_3 (item.amount_3),
		.stat        (stat)
	);

endmodule

FILE: dv/bankers_safety_allocator_top_tb.sv
// Self-checking testbench for the banker's allocator: directed table, fill-up, then random traffic.
module bankers_safety_allocator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bsa_pkg::*;

	logic clk;
	logic arst_n;

	bsa_in_if  item ();
	bsa_out_if result ();

	bankers_safety_allocator_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item.sink),
		.result (result.source)
	);

	always #5 clk = ~clk;

	// Shadow copy of the allocator state
	logic [COUNT_WIDTH-1:0] avail_m [NUM_RES];
	logic [COUNT_WIDTH-1:0] need_m  [MAX_CUSTOMERS][NUM_RES];
	logic [COUNT_WIDTH-1:0] alloc_m [MAX_CUSTOMERS][NUM_RES];
	logic                   active_m [MAX_CUSTOMERS];

	typedef struct {
		logic    granted;
		status_t status;
	} outcome_t;

	typedef struct {
		kind_t             kind;
		logic [SLOT_W-1:0] slot;
		logic [AMT_W-1:0]  amt [4];
		logic              has_exp;
		status_t           exp_status;
	} tbl_row_t;

	outcome_t pending_q [$];
	int       errors;
	bit       stim_done;
	bit       hold_sink;

	// Banker's safety scan over the shadow state
	function automatic bit state_is_safe();
		logic [WORK_W-1:0] work [NUM_RES];
		bit finished [MAX_CUSTOMERS];
		bit moved;
		bit fits;
		for (int r = 0; r < NUM_RES; r++) work[r] = avail_m[r];
		for (int c = 0; c < MAX_CUSTOMERS; c++) finished[c] = !active_m[c];
		moved = 1;
		while (moved) begin
			moved = 0;
			for (int c = 0; c < MAX_CUSTOMERS; c++) begin
				if (!finished[c]) begin
					fits = 1;
					for (int r = 0; r < NUM_RES; r++)
						if (WORK_W'(need_m[c][r] - alloc_m[c][r]) > work[r]) fits = 0;
					if (fits) begin
						for (int r = 0; r < NUM_RES; r++) work[r] += alloc_m[c][r];
						finished[c] = 1;
						moved = 1;
					end
				end
			end
		end
		for (int c = 0; c < MAX_CUSTOMERS; c++)
			if (!finished[c]) return 0;
		return 1;
	endfunction

	// Applies one transaction to the shadow state, returns its status
	function automatic status_t allocate_step(kind_t k, int s, logic [AMT_W-1:0] a [4]);
		logic [COUNT_WIDTH-1:0] v [NUM_RES];
		logic [COUNT_WIDTH:0] sum;
		for (int r = 0; r < NUM_RES; r++) v[r] = (r < AMOUNT_FIELDS) ? a[r] : '0;
		if (k == KIND_SET_AVAIL) begin
			for (int r = 0; r < NUM_RES; r++) avail_m[r] = v[r];
			return ST_OK;
		end
		if (s >= MAX_CUSTOMERS) return ST_SLOT_STATE;
		if (k == KIND_REGISTER) begin
			if (active_m[s]) return ST_SLOT_STATE;
			active_m[s] = 1;
			for (int r = 0; r < NUM_RES; r++) begin
				need_m[s][r]  = v[r];
				alloc_m[s][r] = '0;
			end
			return ST_OK;
		end
		if (!active_m[s]) return ST_SLOT_STATE;
		if (k == KIND_REQUEST) begin
			for (int r = 0; r < NUM_RES; r++)
				if (v[r] > COUNT_WIDTH'(need_m[s][r] - alloc_m[s][r])) return ST_OVER_NEED;
			for (int r = 0; r < NUM_RES; r++)
				if (v[r] > avail_m[r]) return ST_OVER_AVAIL;
			for (int r = 0; r < NUM_RES; r++) begin
				avail_m[r]    -= v[r];
				alloc_m[s][r] += v[r];
			end
			if (state_is_safe()) return ST_OK;
			for (int r = 0; r < NUM_RES; r++) begin
				avail_m[r]    += v[r];
				alloc_m[s][r] -= v[r];
			end
			return ST_UNSAFE;
		end
		for (int r = 0; r < NUM_RES; r++) begin
			sum = avail_m[r] + alloc_m[s][r];
			avail_m[r] = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
			alloc_m[s][r] = '0;
		end
		active_m[s] = 0;
		return ST_OK;
	endfunction

	// Drives one transaction and holds it until accepted
	task automatic send_item(kind_t k, int s, logic [AMT_W-1:0] a [4],
		bit chk, status_t st);
		status_t got;
		got = allocate_step(k, s, a);
		if (chk && got != st) begin
			$display("%0t: table row mismatch expected status %0d actual %0d",
				$time, st, got);
			errors++;
		end
		pending_q.push_back('{granted: (got == ST_OK), status: got});
		item.valid    <= 1'b1;
		item.kind     <= k;
		item.slot     <= SLOT_W'(s);
		item.amount_0 <= a[0];
		item.amount_1 <= a[1];
		item.amount_2 <= a[2];
		item.amount_3 <= a[3];
		@(posedge clk);
		while (!item.ready) @(posedge clk);
	endtask

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
		if ($urandom_range(0, 3) == 0) n = 0;
		if (n > 0) begin
			item.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		item.valid <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0) @(posedge clk);
	endtask

	function automatic logic [AMT_W-1:0] rand_amt(int hi);
		case ($urandom_range(0, 9))
			0: return '1;
			1: return '0;
			2: return AMT_W'($urandom);
			default: return AMT_W'($urandom_range(0, hi));
		endcase
	endfunction

	// Receiver: random backpressure, checks each result against the oldest expectation
	initial begin
		outcome_t e;
		int n;
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result.valid && result.ready) begin
				if (pending_q.size() == 0) begin
					$display("%0t: unexpected result granted %0b status %0d",
						$time, result.granted, result.status);
					errors++;
				end else begin
					e = pending_q.pop_front();
					if (result.granted !== e.granted || result.status !== e.status) begin
						$display("%0t: expected granted %0b status %0d, actual granted %0b status %0d",
							$time, e.granted, e.status, result.granted, result.status);
						errors++;
					end
				end
			end
			if (hold_sink) result.ready <= 1'b0;
			else begin
				n = $urandom_range(0, 19);
				if (n == 18) begin
					// long stall now and then
					result.ready <= 1'b0;
					repeat ($urandom_range(5, 40)) @(posedge clk);
					result.ready <= 1'b1;
				end else begin
					result.ready <= (n < 12) || (n == 19 && stim_done);
				end
			end
		end
	end

	// Stimulus
	initial begin
		tbl_row_t tbl [$];
		logic [AMT_W-1:0] a [4];
		logic [AMT_W-1:0] z [4];
		logic [AMT_W-1:0] mx [4];
		int s;
		int pick;
		kind_t k;

		clk        = 1'b0;
		arst_n     = 1'b0;
		errors     = 0;
		stim_done  = 0;
		hold_sink  = 0;
		item.valid = 1'b0;
		item.kind  = KIND_SET_AVAIL;
		item.slot  = '0;
		item.amount_0 = '0;
		item.amount_1 = '0;
		item.amount_2 = '0;
		item.amount_3 = '0;
		for (int r = 0; r < NUM_RES; r++) avail_m[r] = '0;
		for (int c = 0; c < MAX_CUSTOMERS; c++) begin
			active_m[c] = 0;
			for (int r = 0; r < NUM_RES; r++) begin
				need_m[c][r]  = '0;
				alloc_m[c][r] = '0;
			end
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		z  = '{16'd0, 16'd0, 16'd0, 16'd0};
		mx = '{16'hffff, 16'hffff, 16'hffff, 16'hffff};
		// Directed table: slot errors after reset, zero request, over need/available,
		// unsafe, saturating release, duplicate register
		tbl = '{
			'{KIND_REQUEST,   3'd0, z,  1, ST_SLOT_STATE},
			'{KIND_RELEASE,   3'd7, z,  1, ST_SLOT_STATE},
			'{KIND_REGISTER,  3'd0, mx, 1, ST_OK},
			'{KIND_REGISTER,  3'd0, z,  1, ST_SLOT_STATE},
			'{KIND_REQUEST,   3'd0, z,  1, ST_UNSAFE},
			'{KIND_REQUEST,   3'd0, mx, 1, ST_OVER_AVAIL},
			'{KIND_SET_AVAIL, 3'd5, mx, 1, ST_OK},
			'{KIND_REQUEST,   3'd0, mx, 1, ST_OK},
			'{KIND_RELEASE,   3'd0, z,  1, ST_OK},
			'{KIND_REGISTER,  3'd7, '{16'd10, 16'd10, 16'd10, 16'd10}, 1, ST_OK},
			'{KIND_REQUEST,   3'd7, '{16'd11, 16'd0, 16'd0, 16'd0}, 1, ST_OVER_NEED},
			'{KIND_SET_AVAIL, 3'd0, '{16'd12, 16'd12, 16'd12, 16'd12}, 1, ST_OK},
			'{KIND_REGISTER,  3'd1, '{16'd10, 16'd10, 16'd10, 16'd10}, 1, ST_OK},
			'{KIND_REQUEST,   3'd7, '{16'd5, 16'd5, 16'd5, 16'd5}, 1, ST_OK},
			'{KIND_REQUEST,   3'd1, '{16'd5, 16'd5, 16'd5, 16'd5}, 1, ST_UNSAFE},
			'{KIND_REQUEST,   3'd1, '{16'd2, 16'd2, 16'd2, 16'd2}, 0, ST_OK},
			'{KIND_SET_AVAIL, 3'd0, '{16'hfffe, 16'h0, 16'hffff, 16'h1}, 1, ST_OK},
			'{KIND_RELEASE,   3'd7, z,  1, ST_OK},
			'{KIND_RELEASE,   3'd1, z,  1, ST_OK},
			'{KIND_REGISTER,  3'd4, '{16'h5555, 16'haaaa, 16'h0, 16'hffff}, 0, ST_OK},
			'{KIND_REQUEST,   3'd4, '{16'h5555, 16'h0, 16'h0, 16'hffff}, 0, ST_OK},
			'{KIND_RELEASE,   3'd4, z,  0, ST_OK}
		};
		foreach (tbl[i]) begin
			a = tbl[i].amt;
			send_item(tbl[i].kind, tbl[i].slot, a, tbl[i].has_exp, tbl[i].exp_status);
			idle_gap();
		end

		// Fill-up: receiver holds off for a counted stretch while items keep coming
		hold_sink = 1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_sink = 0;
			end
		join_none
		for (int i = 0; i < 6; i++) begin
			a = '{AMT_W'($urandom), AMT_W'($urandom), AMT_W'($urandom), AMT_W'($urandom)};
			send_item(KIND_SET_AVAIL, 0, a, 0, ST_OK);
		end
		wait_drained();

		// Random part: mostly requests against random slots with smallish amounts
		for (int i = 0; i < 1050; i++) begin
			pick = $urandom_range(0, 99);
			s = $urandom_range(0, MAX_CUSTOMERS - 1);
			if (pick < 6) k = KIND_SET_AVAIL;
			else if (pick < 22) k = KIND_REGISTER;
			else if (pick < 82) k = KIND_REQUEST;
			else k = KIND_RELEASE;
			for (int r = 0; r < 4; r++)
				a[r] = (k == KIND_REQUEST) ? rand_amt(8) :
					(k == KIND_SET_AVAIL) ? rand_amt(60) : rand_amt(30);
			send_item(k, s, a, 0, ST_OK);
			if (i == 500) wait_drained();
			else idle_gap();
		end
		item.valid <= 1'b0;
		stim_done = 1;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0) $display("bankers_safety_allocator_top_tb OK");
		else $display("bankers_safety_allocator_top_tb NOT OK");
		$finish;
	end

	// Timeout guard
	initial begin
		#20ms;
		$display("bankers_safety_allocator_top_tb NOT OK");
		$finish;
	end
endmodule

FILE: files.f
rtl/core/bsa_pkg.sv
rtl/core/bsa_if.sv
rtl/core/bsa_datapath.sv
rtl/core/bsa_ctrl.sv
rtl/core/bankers_safety_allocator_top.sv
dv/bankers_safety_allocator_top_tb.sv
